/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the top-level RTL. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check an implication-style property on every rising edge outside reset
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLKD(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/bcws_pkg.sv */
// ----------------------------------------------------------------------------
// bcws_pkg
// Types, register indexes, wavetables and fixed-point helpers of the bell
// chime synthesizer.
// ----------------------------------------------------------------------------
package bcws_pkg;

	localparam int PHASE_W = 6;
	localparam int AMP_W   = 8;
	localparam int DUTY_W  = 8;
	localparam int REG_IDX_W = 3;

	localparam logic [DUTY_W-1:0] DUTY_MID = 8'd128;

	// Playback mode, also the play_mode output code
	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_SHORT = 2'd1,
		MODE_LONG  = 2'd2
	} mode_t;

	// Configuration register indexes
	typedef enum logic [REG_IDX_W-1:0] {
		REG_FUND_FADE_LONG  = 3'd0,
		REG_FUND_FADE_SHORT = 3'd1,
		REG_OVER_FADE_LONG  = 3'd2,
		REG_OVER_FADE_SHORT = 3'd3,
		REG_FUND_START_AMP  = 3'd4,
		REG_OVER_START_AMP  = 3'd5
	} reg_idx_t;

	// Register reset values
	localparam logic [7:0] FUND_FADE_LONG_RST  = 8'd200;
	localparam logic [7:0] FUND_FADE_SHORT_RST = 8'd120;
	localparam logic [7:0] OVER_FADE_LONG_RST  = 8'd150;
	localparam logic [7:0] OVER_FADE_SHORT_RST = 8'd80;
	localparam logic [7:0] FUND_START_AMP_RST  = 8'd180;
	localparam logic [7:0] OVER_START_AMP_RST  = 8'd200;

	typedef struct packed {
		logic flasher_level;
		logic doors_level;
	} tick_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              drive_on;
		mode_t             play_mode;
	} chime_t;

	// Configuration register file contents
	typedef struct packed {
		logic [7:0] fund_fade_long;
		logic [7:0] fund_fade_short;
		logic [7:0] over_fade_long;
		logic [7:0] over_fade_short;
		logic [AMP_W-1:0] fund_start_amp;
		logic [AMP_W-1:0] over_start_amp;
	} cfg_t;

	// Fundamental partial, one sine period; entries past the period are zero
	function automatic logic signed [7:0] fund_wave(input logic [PHASE_W-1:0] idx);
		logic signed [7:0] v;
		case (idx)
			6'd0:  v = 8'sd0;    6'd1:  v = 8'sd10;   6'd2:  v = 8'sd19;
			6'd3:  v = 8'sd28;   6'd4:  v = 8'sd36;   6'd5:  v = 8'sd44;
			6'd6:  v = 8'sd50;   6'd7:  v = 8'sd55;   6'd8:  v = 8'sd60;
			6'd9:  v = 8'sd62;   6'd10: v = 8'sd64;   6'd11: v = 8'sd64;
			6'd12: v = 8'sd62;   6'd13: v = 8'sd60;   6'd14: v = 8'sd55;
			6'd15: v = 8'sd50;   6'd16: v = 8'sd44;   6'd17: v = 8'sd36;
			6'd18: v = 8'sd28;   6'd19: v = 8'sd19;   6'd20: v = 8'sd10;
			6'd21: v = 8'sd0;    6'd22: v = -8'sd10;  6'd23: v = -8'sd19;
			6'd24: v = -8'sd28;  6'd25: v = -8'sd36;  6'd26: v = -8'sd44;
			6'd27: v = -8'sd50;  6'd28: v = -8'sd55;  6'd29: v = -8'sd60;
			6'd30: v = -8'sd62;  6'd31: v = -8'sd64;  6'd32: v = -8'sd64;
			6'd33: v = -8'sd62;  6'd34: v = -8'sd60;  6'd35: v = -8'sd55;
			6'd36: v = -8'sd50;  6'd37: v = -8'sd44;  6'd38: v = -8'sd36;
			6'd39: v = -8'sd28;  6'd40: v = -8'sd19;  6'd41: v = -8'sd10;
			default: v = 8'sd0;
		endcase
		return v;
	endfunction

	// Overtone partial; entries past the period are zero
	function automatic logic signed [7:0] over_wave(input logic [PHASE_W-1:0] idx);
		logic signed [7:0] v;
		case (idx)
			6'd0:  v = 8'sd0;    6'd1:  v = 8'sd12;   6'd2:  v = 8'sd23;
			6'd3:  v = 8'sd32;   6'd4:  v = 8'sd38;   6'd5:  v = 8'sd41;
			6'd6:  v = 8'sd42;   6'd7:  v = 8'sd42;   6'd8:  v = 8'sd42;
			6'd9:  v = 8'sd40;   6'd10: v = 8'sd38;   6'd11: v = 8'sd36;
			6'd12: v = 8'sd34;   6'd13: v = 8'sd32;   6'd14: v = 8'sd30;
			6'd15: v = 8'sd28;   6'd16: v = 8'sd26;   6'd17: v = 8'sd24;
			6'd18: v = 8'sd22;   6'd19: v = 8'sd20;   6'd20: v = 8'sd18;
			6'd21: v = 8'sd16;   6'd22: v = 8'sd15;   6'd23: v = 8'sd13;
			6'd24: v = 8'sd12;   6'd25: v = 8'sd10;   6'd26: v = 8'sd9;
			6'd27: v = 8'sd7;    6'd28: v = 8'sd6;    6'd29: v = 8'sd4;
			6'd30: v = 8'sd3;    6'd31: v = 8'sd1;    6'd32: v = 8'sd0;
			6'd33: v = -8'sd1;   6'd34: v = -8'sd3;   6'd35: v = -8'sd4;
			6'd36: v = -8'sd6;   6'd37: v = -8'sd7;   6'd38: v = -8'sd9;
			6'd39: v = -8'sd10;  6'd40: v = -8'sd12;  6'd41: v = -8'sd13;
			default: v = 8'sd0;
		endcase
		return v;
	endfunction

	// Signed sample times unsigned amplitude, floor-shifted right by 8, low byte
	function automatic logic [DUTY_W-1:0] scale(input logic signed [7:0] s,
			input logic [AMP_W-1:0] u);
		logic signed [16:0] p;
		p = $signed({{9{s[7]}}, s}) * $signed({9'b0, u});
		return p[15:8];
	endfunction

endpackage

/* rtl/bcws_cfg.sv */
// ----------------------------------------------------------------------------
// bcws_cfg
// Configuration register file: fade periods and strike amplitudes.
// ----------------------------------------------------------------------------
module bcws_cfg import bcws_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [7:0]           wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Write the addressed register; drop writes to unused indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fund_fade_long  <= FUND_FADE_LONG_RST;
			cfg_q.fund_fade_short <= FUND_FADE_SHORT_RST;
			cfg_q.over_fade_long  <= OVER_FADE_LONG_RST;
			cfg_q.over_fade_short <= OVER_FADE_SHORT_RST;
			cfg_q.fund_start_amp  <= FUND_START_AMP_RST;
			cfg_q.over_start_amp  <= OVER_START_AMP_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_FUND_FADE_LONG:  cfg_q.fund_fade_long  <= wr_data;
				REG_FUND_FADE_SHORT: cfg_q.fund_fade_short <= wr_data;
				REG_OVER_FADE_LONG:  cfg_q.over_fade_long  <= wr_data;
				REG_OVER_FADE_SHORT: cfg_q.over_fade_short <= wr_data;
				REG_FUND_START_AMP:  cfg_q.fund_start_amp  <= wr_data;
				REG_OVER_START_AMP:  cfg_q.over_start_amp  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/bcws_voice.sv */
// ----------------------------------------------------------------------------
// bcws_voice
// Voice state and single-pass tick update: mode control, decay dividers,
// wavetable lookup and duty mix.
// ----------------------------------------------------------------------------
module bcws_voice import bcws_pkg::*; #(
	parameter int TABLE_LEN = 42
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   advance,
	input  tick_t  tick,
	input  cfg_t   cfg,
	output chime_t result
);

	localparam logic [PHASE_W:0] PHASE_END = (PHASE_W+1)'(TABLE_LEN);

	mode_t              mode_q;
	logic [PHASE_W-1:0] phase_q;
	logic [AMP_W-1:0]   fund_amp_q, over_amp_q;
	logic [7:0]         fund_div_q, over_div_q;
	logic [DUTY_W-1:0]  last_duty_q;

	mode_t              mode_eff, mode_d;
	logic               active;
	logic [7:0]         ffade, ofade;
	logic [PHASE_W-1:0] phase_rd, phase_inc, phase_d;
	logic [AMP_W-1:0]   fund_amp_d, over_amp_pre, over_amp_d;
	logic [7:0]         fund_div_d, over_div_pre, over_div_d;
	logic [DUTY_W-1:0]  duty_d;

	// Trigger: a mode starts only from idle, doors wins
	always_comb begin
		mode_eff = mode_q;
		if (mode_q == MODE_IDLE) begin
			if (tick.flasher_level)
				mode_eff = MODE_SHORT;
			if (!tick.doors_level)
				mode_eff = MODE_LONG;
		end
		active = (mode_eff != MODE_IDLE);
	end

	// Next state: drop back to idle once the fundamental has died out
	always_comb begin
		if (active && fund_amp_d != '0)
			mode_d = mode_eff;
		else
			mode_d = MODE_IDLE;
	end

	// Datapath: step the dividers, look up both partials, mix
	always_comb begin
		ffade = (mode_eff == MODE_LONG) ? cfg.fund_fade_long : cfg.fund_fade_short;
		ofade = (mode_eff == MODE_LONG) ? cfg.over_fade_long : cfg.over_fade_short;

		fund_amp_d   = fund_amp_q;
		fund_div_d   = fund_div_q;
		over_amp_pre = over_amp_q;
		over_div_pre = over_div_q;
		phase_rd     = phase_q;

		// Fundamental divider; a strike reloads both partials and the phase
		if (fund_div_q == '0) begin
			fund_div_d = ffade;
			if (fund_amp_q == '0) begin
				fund_amp_d   = cfg.fund_start_amp;
				over_amp_pre = cfg.over_start_amp;
				over_div_pre = ofade;
				phase_rd     = '0;
			end else begin
				fund_amp_d = fund_amp_q - 1'b1;
			end
		end else begin
			fund_div_d = fund_div_q - 1'b1;
		end

		// Overtone divider, amplitude stops at zero
		over_amp_d = over_amp_pre;
		if (over_div_pre == '0) begin
			over_div_d = ofade;
			if (over_amp_pre != '0)
				over_amp_d = over_amp_pre - 1'b1;
		end else begin
			over_div_d = over_div_pre - 1'b1;
		end

		duty_d = DUTY_MID + scale(fund_wave(phase_rd), fund_amp_d)
			+ scale(over_wave(phase_rd), over_amp_d);

		// Advance the phase and wrap at the table length
		phase_inc = phase_rd + 1'b1;
		phase_d   = ({1'b0, phase_inc} >= PHASE_END) ? '0 : phase_inc;
	end

	// Commit the tick on an accepted transaction; idle ticks hold everything
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			phase_q     <= '0;
			fund_amp_q  <= '0;
			over_amp_q  <= '0;
			fund_div_q  <= '0;
			over_div_q  <= '0;
			last_duty_q <= DUTY_MID;
		end else if (advance) begin
			mode_q <= mode_d;
			if (active) begin
				phase_q     <= phase_d;
				fund_amp_q  <= fund_amp_d;
				over_amp_q  <= over_amp_d;
				fund_div_q  <= fund_div_d;
				over_div_q  <= over_div_d;
				last_duty_q <= duty_d;
			end
		end
	end

	// Result of this tick
	always_comb begin
		result.duty      = active ? duty_d : last_duty_q;
		result.drive_on  = (mode_d != MODE_IDLE);
		result.play_mode = mode_d;
	end

endmodule

/* rtl/bell_chime_wavetable_synth.sv */
// ----------------------------------------------------------------------------
// bell_chime_wavetable_synth: two-partial decaying bell tone PWM synthesizer
// Latency: a result is valid in the cycle after its tick transaction.
// Throughput: one tick per cycle unless a waiting result is stalled, set by the single-pass voice update.
// Reset: arst_n clears voice state to idle, duty to 128, registers to defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bell_chime_wavetable_synth import bcws_pkg::*; #(
	parameter int TABLE_LEN = 42
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Tick channel
	input  logic                 tick_valid,
	output logic                 tick_stall,
	input  tick_t                tick,
	// Result channel
	output logic                 chime_valid,
	input  logic                 chime_stall,
	output chime_t               chime,
	// Configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	cfg_t   cfg;
	chime_t result;
	chime_t chime_q;
	logic   chime_valid_q;
	logic   tick_accept;

	// Hold the tick channel only while a result waits and is not taken
	assign tick_stall  = chime_valid_q && chime_stall;
	assign tick_accept = tick_valid && !tick_stall;
	assign cfg_ready   = 1'b1;

	bcws_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	bcws_voice #(
		.TABLE_LEN (TABLE_LEN)
	) u_voice (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (tick_accept),
		.tick    (tick),
		.cfg     (cfg),
		.result  (result)
	);

	// Output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chime_valid_q <= 1'b0;
		end else if (tick_accept) begin
			chime_valid_q <= 1'b1;
		end else if (!chime_stall) begin
			chime_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (tick_accept) begin
			chime_q <= result;
		end
	end

	assign chime_valid = chime_valid_q;
	assign chime       = chime_q;

	// Every accepted tick yields a result in the next cycle
	`ASSERT_CLKD(a_tick_gives_result, clk, arst_n,
		(tick_valid && !tick_stall) |=> chime_valid, "accepted tick produced no result")

	// Drive is on exactly when a mode is active
	`ASSERT_CLKD(a_drive_matches_mode, clk, arst_n,
		chime_valid |-> (chime.drive_on == (chime.play_mode != MODE_IDLE)),
		"drive_on disagrees with play_mode")

	// A mode change never skips idle between short and long chimes
	`ASSERT_NEVER(a_no_mode_jump, clk, arst_n,
		chime_valid && $past(chime_valid) && !$past(chime_stall)
		&& $past(chime.play_mode) != MODE_IDLE && chime.play_mode != MODE_IDLE
		&& chime.play_mode != $past(chime.play_mode),
		"play_mode switched between active modes without idle")

endmodule

/* tb/tb_bell_chime_wavetable_synth.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bell_chime_wavetable_synth
// Self-checking bench for the bell chime synthesizer. A tick-level model of
// the two decaying partials predicts every chime transaction. Directed tests
// cover reset values, trigger priority, retrigger blips, zero amplitude and
// register extremes. A random phase then strikes many short chimes under
// varying sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_bell_chime_wavetable_synth;
	import bcws_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int WAVE_LEN     = 42;
	localparam int NUM_REGS     = 6;
	localparam int RANDOM_TICKS = 150;
	localparam int PRINT_CAP    = 50;

	logic                 clk;
	logic                 arst_n;
	logic                 tick_valid;
	logic                 tick_stall;
	tick_t                tick;
	logic                 chime_valid;
	logic                 chime_stall;
	chime_t               chime;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	// One period of each partial
	logic signed [7:0] fund_samples [0:WAVE_LEN-1] = '{
		8'sd0, 8'sd10, 8'sd19, 8'sd28, 8'sd36, 8'sd44, 8'sd50, 8'sd55, 8'sd60,
		8'sd62, 8'sd64, 8'sd64, 8'sd62, 8'sd60, 8'sd55, 8'sd50, 8'sd44, 8'sd36,
		8'sd28, 8'sd19, 8'sd10, 8'sd0, -8'sd10, -8'sd19, -8'sd28, -8'sd36,
		-8'sd44, -8'sd50, -8'sd55, -8'sd60, -8'sd62, -8'sd64, -8'sd64, -8'sd62,
		-8'sd60, -8'sd55, -8'sd50, -8'sd44, -8'sd36, -8'sd28, -8'sd19, -8'sd10
	};
	logic signed [7:0] over_samples [0:WAVE_LEN-1] = '{
		8'sd0, 8'sd12, 8'sd23, 8'sd32, 8'sd38, 8'sd41, 8'sd42, 8'sd42, 8'sd42,
		8'sd40, 8'sd38, 8'sd36, 8'sd34, 8'sd32, 8'sd30, 8'sd28, 8'sd26, 8'sd24,
		8'sd22, 8'sd20, 8'sd18, 8'sd16, 8'sd15, 8'sd13, 8'sd12, 8'sd10, 8'sd9,
		8'sd7, 8'sd6, 8'sd4, 8'sd3, 8'sd1, 8'sd0, -8'sd1, -8'sd3, -8'sd4,
		-8'sd6, -8'sd7, -8'sd9, -8'sd10, -8'sd12, -8'sd13
	};

	// Voice model state and register shadow
	mode_t      voice_mode;
	logic [5:0] voice_phase;
	logic [7:0] fund_level;
	logic [7:0] over_level;
	logic [7:0] fund_count;
	logic [7:0] over_count;
	logic [7:0] held_duty;
	logic [7:0] reg_shadow [0:NUM_REGS-1];

	chime_t expected_chimes [$];

	int gap_pct;
	int stall_pct;
	int mismatches;
	int ticks_sent;
	int chimes_checked;
	int strikes;
	int reg_writes;

	bell_chime_wavetable_synth #(
		.TABLE_LEN(WAVE_LEN)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.tick       (tick),
		.chime_valid(chime_valid),
		.chime_stall(chime_stall),
		.chime      (chime),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Stop a hung run
	initial begin
		#(CLK_PERIOD * 1_000_000);
		$display("Timeout: chime transactions stopped flowing");
		$display("Simulation FAILED");
		$finish;
	end

	// Sample times level, floor-shifted by 8, kept as a byte
	function automatic logic [7:0] weigh(input logic signed [7:0] sample,
			input logic [7:0] level);
		int prod;
		prod = int'(sample) * int'(level);
		return 8'(prod >>> 8);
	endfunction

	// Advance the voice by one tick and return the chime it produces
	function automatic chime_t advance_voice(input logic flasher, input logic doors);
		logic [7:0] fund_fade;
		logic [7:0] over_fade;
		chime_t     res;
		if (voice_mode == MODE_IDLE) begin
			if (flasher)
				voice_mode = MODE_SHORT;
			if (!doors)
				voice_mode = MODE_LONG;
		end
		if (voice_mode != MODE_IDLE) begin
			fund_fade = (voice_mode == MODE_LONG) ? reg_shadow[REG_FUND_FADE_LONG]
				: reg_shadow[REG_FUND_FADE_SHORT];
			over_fade = (voice_mode == MODE_LONG) ? reg_shadow[REG_OVER_FADE_LONG]
				: reg_shadow[REG_OVER_FADE_SHORT];
			// Fundamental divider; a strike happens only with both count and level at zero
			if (fund_count == 8'd0) begin
				fund_count = fund_fade;
				if (fund_level == 8'd0) begin
					fund_level  = reg_shadow[REG_FUND_START_AMP];
					over_level  = reg_shadow[REG_OVER_START_AMP];
					over_count  = over_fade;
					voice_phase = 6'd0;
					strikes++;
				end else begin
					fund_level = fund_level - 8'd1;
				end
			end else begin
				fund_count = fund_count - 8'd1;
			end
			// Overtone divider; level saturates at zero
			if (over_count == 8'd0) begin
				over_count = over_fade;
				if (over_level != 8'd0)
					over_level = over_level - 8'd1;
			end else begin
				over_count = over_count - 8'd1;
			end
			held_duty = DUTY_MID + weigh(fund_samples[voice_phase], fund_level)
				+ weigh(over_samples[voice_phase], over_level);
			voice_phase = (voice_phase == WAVE_LEN - 1) ? 6'd0 : voice_phase + 6'd1;
			if (fund_level == 8'd0)
				voice_mode = MODE_IDLE;
		end
		res.duty      = held_duty;
		res.drive_on  = (voice_mode != MODE_IDLE);
		res.play_mode = voice_mode;
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_CAP)
			$display("MISMATCH @%0t: %s", $time, what);
		mismatches++;
	endtask

	// Select one of the idling phases
	task automatic set_pace(input int phase);
		case (phase % 4)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 73; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 73; end
			default: begin gap_pct = 17; stall_pct = 17; end
		endcase
	endtask

	// Send one tick transaction and queue its predicted chime
	task automatic send_tick(input logic flasher, input logic doors);
		while ($urandom_range(99) < gap_pct) begin
			tick_valid <= 1'b0;
			@(posedge clk);
		end
		expected_chimes.push_back(advance_voice(flasher, doors));
		tick_valid <= 1'b1;
		tick       <= '{flasher_level: flasher, doors_level: doors};
		do @(posedge clk); while (tick_stall);
		ticks_sent++;
	endtask

	// Drop the tick channel and wait for every pending chime
	task automatic wait_drained();
		tick_valid <= 1'b0;
		do @(posedge clk); while (expected_chimes.size() != 0);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx < NUM_REGS)
			reg_shadow[idx] = value;
		reg_writes++;
		cfg_valid <= 1'b0;
	endtask

	task automatic set_fades(input logic [7:0] fund_long, input logic [7:0] fund_short,
			input logic [7:0] over_long, input logic [7:0] over_short);
		write_reg(REG_FUND_FADE_LONG, fund_long);
		write_reg(REG_FUND_FADE_SHORT, fund_short);
		write_reg(REG_OVER_FADE_LONG, over_long);
		write_reg(REG_OVER_FADE_SHORT, over_short);
	endtask

	task automatic set_amps(input logic [7:0] fund_amp, input logic [7:0] over_amp);
		write_reg(REG_FUND_START_AMP, fund_amp);
		write_reg(REG_OVER_START_AMP, over_amp);
	endtask

	// Tick with random trigger levels until the chime dies out
	task automatic play_out();
		while (voice_mode != MODE_IDLE)
			send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	// Hold a trigger until a real strike (blips run the divider down), then play out
	task automatic strike(input logic flasher, input logic doors);
		int strikes_before;
		strikes_before = strikes;
		do send_tick(flasher, doors);
		while (strikes == strikes_before && voice_mode == MODE_IDLE);
		play_out();
	endtask

	// Check each accepted chime against the oldest prediction; stall at random
	always @(posedge clk) begin : chime_monitor
		chime_t want;
		if (arst_n) begin
			if (chime_valid && !chime_stall) begin
				chimes_checked++;
				if (expected_chimes.size() == 0) begin
					report_mismatch("chime transaction with no tick waiting");
				end else begin
					want = expected_chimes.pop_front();
					if (chime.duty !== want.duty)
						report_mismatch($sformatf("duty got %0d want %0d",
							chime.duty, want.duty));
					if (chime.drive_on !== want.drive_on)
						report_mismatch($sformatf("drive_on got %b want %b",
							chime.drive_on, want.drive_on));
					if (chime.play_mode !== want.play_mode)
						report_mismatch($sformatf("play_mode got %0d want %0d",
							chime.play_mode, want.play_mode));
				end
			end
			chime_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic test_idle_hold();
		set_pace(0);
		repeat (4) send_tick(1'b0, 1'b1);
	endtask

	// Strike the short mode at reset values, then speed the decay to finish
	task automatic test_default_strikes();
		set_pace(1);
		send_tick(1'b1, 1'b1);
		repeat (5) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
		write_reg(REG_FUND_FADE_SHORT, 8'd0);
		write_reg(REG_OVER_FADE_SHORT, 8'd0);
		play_out();
	endtask

	// Doors wins over flasher; each single line alone
	task automatic test_trigger_priority();
		set_pace(2);
		set_fades(8'd0, 8'd0, 8'd1, 8'd2);
		set_amps(8'd3, 8'd255);
		strike(1'b1, 1'b0);
		strike(1'b0, 1'b0);
		strike(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
	endtask

	// Trigger while the fundamental divider still runs: one-tick blips
	task automatic test_retrigger();
		set_pace(3);
		set_fades(8'd5, 8'd5, 8'd1, 8'd1);
		set_amps(8'd1, 8'd2);
		strike(1'b1, 1'b1);
		repeat (3) send_tick(1'b0, 1'b0);
		repeat (3) send_tick(1'b1, 1'b0);
		play_out();
	endtask

	// Zero fundamental start ends the chime in its strike tick
	task automatic test_zero_start();
		set_pace(0);
		set_fades(8'd0, 8'd0, 8'd0, 8'd0);
		set_amps(8'd0, 8'd255);
		strike(1'b1, 1'b1);
		strike(1'b0, 1'b0);
	endtask

	// Full amplitude and full overtone fade; unmapped indexes change nothing
	task automatic test_register_extremes();
		set_pace(1);
		set_amps(8'd255, 8'd255);
		set_fades(8'd0, 8'd0, 8'd255, 8'd255);
		strike(1'b0, 1'b0);
		set_amps(8'd2, 8'd3);
		for (int i = NUM_REGS; i < 2 ** REG_IDX_W; i++)
			write_reg(REG_IDX_W'(i), 8'hFF);
		strike(1'b1, 1'b1);
	endtask

	// Mostly clean strikes with fresh settings, some random trigger noise
	task automatic test_random_chimes();
		int stop_at;
		int seq;
		stop_at = ticks_sent + RANDOM_TICKS;
		seq = 0;
		while (ticks_sent < stop_at) begin
			set_pace(seq);
			seq++;
			if ($urandom_range(19) == 0) begin
				set_fades(8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'($urandom_range(255)));
				set_amps(8'($urandom_range(1)), 8'($urandom_range(255)));
			end else begin
				set_fades(8'($urandom_range(3)), 8'($urandom_range(3)),
					8'($urandom_range(3)), 8'($urandom_range(3)));
				set_amps(8'($urandom_range(12)), 8'($urandom_range(255)));
			end
			case ($urandom_range(9))
				0, 1: begin
					repeat ($urandom_range(1, 6))
						send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
					play_out();
				end
				2, 3, 4: strike(1'b1, 1'b1);
				5, 6, 7: strike(1'b0, 1'b0);
				default: strike(1'b1, 1'b0);
			endcase
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		tick_valid  <= 1'b0;
		tick        <= '0;
		chime_stall <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;

		// Model state after reset
		voice_mode  = MODE_IDLE;
		voice_phase = 6'd0;
		fund_level  = 8'd0;
		over_level  = 8'd0;
		fund_count  = 8'd0;
		over_count  = 8'd0;
		held_duty   = DUTY_MID;
		reg_shadow[REG_FUND_FADE_LONG]  = FUND_FADE_LONG_RST;
		reg_shadow[REG_FUND_FADE_SHORT] = FUND_FADE_SHORT_RST;
		reg_shadow[REG_OVER_FADE_LONG]  = OVER_FADE_LONG_RST;
		reg_shadow[REG_OVER_FADE_SHORT] = OVER_FADE_SHORT_RST;
		reg_shadow[REG_FUND_START_AMP]  = FUND_START_AMP_RST;
		reg_shadow[REG_OVER_START_AMP]  = OVER_START_AMP_RST;
		gap_pct        = 0;
		stall_pct      = 0;
		mismatches     = 0;
		ticks_sent     = 0;
		chimes_checked = 0;
		strikes        = 0;
		reg_writes     = 0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_hold();
		test_default_strikes();
		test_trigger_priority();
		test_retrigger();
		test_zero_start();
		test_register_extremes();
		test_random_chimes();

		wait_drained();
		repeat (4) @(posedge clk);
		if (expected_chimes.size() != 0)
			report_mismatch($sformatf("%0d chimes never arrived", expected_chimes.size()));

		$display("Sent %0d ticks with %0d strikes and %0d register writes",
			ticks_sent, strikes, reg_writes);
		$display("Checked %0d chimes, %0d mismatches", chimes_checked, mismatches);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/bcws_pkg.sv
rtl/bcws_cfg.sv
rtl/bcws_voice.sv
rtl/bell_chime_wavetable_synth.sv
tb/tb_bell_chime_wavetable_synth.sv
